@@ hw/rtl/pwmb_pkg.sv @@
// Package for the PWM output driver with timed blink: types, codes and helpers.
package pwmb_pkg;

	// Scale applied to the PWM level for the steady drive (1 to 255)
	localparam logic [7:0] PWM_SCALE = 8'd1;

	localparam logic [7:0] DRIVE_FULL = 8'hFF;
	localparam logic [7:0] DRIVE_OFF  = 8'h00;
	localparam logic [31:0] COUNT_SAT = 32'hFFFF_FFFF;

	// Operation codes
	localparam logic [2:0] OP_TICK      = 3'd0;
	localparam logic [2:0] OP_SET_POWER = 3'd1;
	localparam logic [2:0] OP_TOGGLE    = 3'd2;
	localparam logic [2:0] OP_SET_LEVEL = 3'd3;
	localparam logic [2:0] OP_BLINK     = 3'd4;

	typedef struct packed {
		logic [2:0]  operation;
		logic        power_value;
		logic [7:0]  level_value;
		logic [31:0] blink_length_ms;
		logic [31:0] blink_period_ms;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  drive_level;
		logic        power_on;
		logic        blink_active;
		logic [31:0] remaining_ms;
	} status_t;

	// Steady drive: level times scale while powered, saturating at full
	function automatic logic [7:0] steady_drive(input logic pwr, input logic [7:0] level);
		logic [15:0] prod;
		prod = 16'(level) * 16'(PWM_SCALE);
		if (!pwr) begin
			return DRIVE_OFF;
		end else if (prod > 16'(DRIVE_FULL)) begin
			return DRIVE_FULL;
		end else begin
			return prod[7:0];
		end
	endfunction

endpackage

@@ hw/rtl/pwmb_stream_if.sv @@
// Valid/ready channel carrying one payload beat.
interface pwmb_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/pwm_output_with_timed_blink_top.sv @@
// Top level of the PWM output driver with timed blink.
//
//   channel  direction  payload   meaning
//   cmd      sink       cmd_t     one event beat: tick, power, level or blink
//   status   source     status_t  one status beat per event
//
// Each event is registered in the input register, processed against the stored
// state, and its status beat lands in the output register; one event per cycle
// is sustained while the status side does not stall. The state update and the output
// register load happen together, so a stalled status side holds the event in
// the input register; cmd stays ready while that register is free.
// Reset (arst_n low) clears all state and empties both registers.
module pwm_output_with_timed_blink_top
	import pwmb_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	pwmb_stream_if.sink     cmd,
	pwmb_stream_if.source   status
);

	// Pipeline registers
	logic    valid_s1;
	cmd_t    item_s1;
	logic    out_valid_q;
	status_t out_data_q;
	logic    advance;

	// Driver state
	logic        power_q, power_d;
	logic [7:0]  level_q, level_d;
	logic        blink_q, blink_d;
	logic        phase_q, phase_d;
	logic [31:0] elapsed_q, elapsed_d;
	logic [31:0] since_q, since_d;
	logic [31:0] length_q, length_d;
	logic [31:0] period_q, period_d;
	logic [7:0]  drive_q, drive_d;
	logic [31:0] since_inc;
	logic        new_power;

	assign advance   = valid_s1 && (!out_valid_q || status.ready);
	assign cmd.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.data;
		end
	end

	// Next state for the event held in the input register
	always_comb begin
		power_d   = power_q;
		level_d   = level_q;
		blink_d   = blink_q;
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		since_d   = since_q;
		length_d  = length_q;
		period_d  = period_q;
		drive_d   = drive_q;
		since_inc = (since_q == COUNT_SAT) ? since_q : since_q + 32'd1;
		new_power = power_q;
		case (item_s1.operation)
			OP_TICK: begin
				if (blink_q) begin
					if (elapsed_q >= length_q) begin
						blink_d   = 1'b0;
						phase_d   = 1'b0;
						elapsed_d = '0;
						since_d   = COUNT_SAT;
						length_d  = '0;
						period_d  = '0;
						drive_d   = steady_drive(power_q, level_q);
					end else begin
						elapsed_d = elapsed_q + 32'd1;
						since_d   = since_inc;
						if (since_inc > (period_q >> 1)) begin
							phase_d = !phase_q;
							drive_d = phase_q ? DRIVE_OFF : DRIVE_FULL;
							since_d = '0;
						end
					end
				end
			end
			OP_SET_POWER, OP_TOGGLE, OP_SET_LEVEL: begin
				if (item_s1.operation == OP_SET_POWER) begin
					new_power = item_s1.power_value;
				end else if (item_s1.operation == OP_TOGGLE) begin
					new_power = !power_q;
				end
				if (item_s1.operation == OP_SET_LEVEL) begin
					level_d = item_s1.level_value;
				end
				// Any of these cancels a running blink
				power_d   = new_power;
				blink_d   = 1'b0;
				phase_d   = 1'b0;
				elapsed_d = '0;
				since_d   = COUNT_SAT;
				length_d  = '0;
				period_d  = '0;
				drive_d   = steady_drive(new_power, level_d);
			end
			OP_BLINK: begin
				phase_d   = 1'b0;
				elapsed_d = '0;
				since_d   = COUNT_SAT;
				if (item_s1.blink_length_ms == '0 || item_s1.blink_period_ms == '0) begin
					blink_d  = 1'b0;
					length_d = '0;
					period_d = '0;
					drive_d  = steady_drive(power_q, level_q);
				end else begin
					blink_d  = 1'b1;
					length_d = item_s1.blink_length_ms;
					period_d = item_s1.blink_period_ms;
				end
			end
			default: begin
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q   <= 1'b0;
			level_q   <= '0;
			blink_q   <= 1'b0;
			phase_q   <= 1'b0;
			elapsed_q <= '0;
			since_q   <= COUNT_SAT;
			length_q  <= '0;
			period_q  <= '0;
			drive_q   <= '0;
		end else if (advance) begin
			power_q   <= power_d;
			level_q   <= level_d;
			blink_q   <= blink_d;
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			since_q   <= since_d;
			length_q  <= length_d;
			period_q  <= period_d;
			drive_q   <= drive_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.drive_level  <= drive_d;
			out_data_q.power_on     <= power_d;
			out_data_q.blink_active <= blink_d;
			out_data_q.remaining_ms <= blink_d ? (length_d - elapsed_d) : '0;
		end
	end

	assign status.valid = out_valid_q;
	assign status.data  = out_data_q;

`ifndef SYNTHESIS
	// Idle blink state sits at its cleared values
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!blink_q |-> (elapsed_q == '0 && since_q == COUNT_SAT && length_q == '0))
		else $error("blink fields not cleared while idle");

	// Elapsed time never runs past the blink length
	a_elapsed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		blink_q |-> (elapsed_q <= length_q))
		else $error("blink elapsed past length");

	// A held event must not touch the state
	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> ($stable(elapsed_q) && $stable(drive_q)))
		else $error("state changed while event was held");

	// No blink reported means no time left
	a_rem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(status.valid && !status.data.blink_active) |-> (status.data.remaining_ms == '0))
		else $error("remaining time without blink");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the PWM output driver with timed blink.
module tb_top;
	import pwmb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Spare operation codes: the block must leave its state alone
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	localparam int RANDOM_EVENTS = 1600;
	localparam int MAX_GAP       = 16;
	localparam int STALL_LIMIT   = 1000;

	logic clk;
	logic arst_n;

	pwmb_stream_if #(.payload_t(cmd_t))    cmd_if ();
	pwmb_stream_if #(.payload_t(status_t)) status_if ();

	pwm_output_with_timed_blink_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.status (status_if)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Mirror of the driver state
	logic        pwr_flag;
	logic [7:0]  pwm_lvl;
	logic        blinking;
	logic        phase_high;
	logic [31:0] elapsed_ms;
	logic [31:0] since_toggle_ms;
	logic [31:0] blink_len;
	logic [31:0] blink_per;
	logic [7:0]  drive_reg;

	cmd_t    pending_cmds[$];
	status_t expected_status[$];

	bit cmd_beat;
	bit status_beat;
	int errors;
	int events_done;
	int blinks_started;
	int blinks_expired;
	int blink_toggles;
	int quiet_cycles;

	int  src_gap;
	int  sink_wait;
	bit  src_busy_mode;
	bit  sink_busy_mode;

	// Steady drive: level times scale while powered, clipped to full
	function automatic logic [7:0] steady_level();
		logic [15:0] prod;
		prod = 16'(pwm_lvl) * 16'(PWM_SCALE);
		if (!pwr_flag)
			return 8'd0;
		return (prod > 16'd255) ? 8'hFF : prod[7:0];
	endfunction

	function automatic void cancel_blink();
		blinking        = 1'b0;
		phase_high      = 1'b0;
		elapsed_ms      = '0;
		since_toggle_ms = '1;
		blink_len       = '0;
		blink_per       = '0;
	endfunction

	function automatic void set_power(logic p);
		if (blinking)
			cancel_blink();
		pwr_flag  = p;
		drive_reg = steady_level();
	endfunction

	function automatic void reset_mirror();
		pwr_flag  = 1'b0;
		pwm_lvl   = '0;
		drive_reg = '0;
		cancel_blink();
	endfunction

	// Advance the mirror by one event and return the status it reports
	function automatic status_t next_status(cmd_t c);
		status_t s;
		case (c.operation)
			OP_TICK: begin
				if (blinking) begin
					if ({1'b0, elapsed_ms} + 33'd1 > {1'b0, blink_len}) begin
						cancel_blink();
						drive_reg = steady_level();
						blinks_expired++;
					end else begin
						elapsed_ms = elapsed_ms + 32'd1;
						if (since_toggle_ms != '1)
							since_toggle_ms = since_toggle_ms + 32'd1;
						if (since_toggle_ms > (blink_per >> 1)) begin
							phase_high      = !phase_high;
							drive_reg       = phase_high ? DRIVE_FULL : DRIVE_OFF;
							since_toggle_ms = '0;
							blink_toggles++;
						end
					end
				end
			end
			OP_SET_POWER: set_power(c.power_value);
			OP_TOGGLE:    set_power(!pwr_flag);
			OP_SET_LEVEL: begin
				pwm_lvl = c.level_value;
				set_power(pwr_flag);
			end
			OP_BLINK: begin
				if (c.blink_length_ms == '0 || c.blink_period_ms == '0) begin
					cancel_blink();
					drive_reg = steady_level();
				end else begin
					blinking        = 1'b1;
					phase_high      = 1'b0;
					elapsed_ms      = '0;
					since_toggle_ms = '1;
					blink_len       = c.blink_length_ms;
					blink_per       = c.blink_period_ms;
					blinks_started++;
				end
			end
			default: ;
		endcase
		s.drive_level  = drive_reg;
		s.power_on     = pwr_flag;
		s.blink_active = blinking;
		s.remaining_ms = (blinking && elapsed_ms <= blink_len) ? blink_len - elapsed_ms : '0;
		return s;
	endfunction

	function automatic cmd_t random_cmd(logic [2:0] op);
		cmd_t c;
		c.operation       = op;
		c.power_value     = 1'($urandom);
		c.level_value     = 8'($urandom);
		c.blink_length_ms = $urandom;
		c.blink_period_ms = $urandom;
		return c;
	endfunction

	// Wait before the next beat; busy mode flips now and then for idle-free stretches
	function automatic int draw_wait(inout bit busy);
		if ($urandom_range(0, 49) == 0)
			busy = !busy;
		return busy ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		end
	endtask

	// Command driver: new beat at the falling edge, held until taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (cmd_if.valid && !cmd_beat) begin
				// beat still waiting for ready
			end else if (src_gap > 0) begin
				src_gap = src_gap - 1;
				cmd_if.valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				cmd_if.data  <= pending_cmds.pop_front();
				cmd_if.valid <= 1'b1;
				src_gap = draw_wait(src_busy_mode);
			end else begin
				cmd_if.valid <= 1'b0;
			end
		end
	end

	// Status sink: after each beat, holds ready low for a random wait, none in busy mode
	always @(negedge clk) begin
		if (arst_n) begin
			if (status_beat)
				sink_wait = draw_wait(sink_busy_mode);
			if (sink_wait > 0) begin
				sink_wait = sink_wait - 1;
				status_if.ready <= 1'b0;
			end else begin
				status_if.ready <= 1'b1;
			end
		end
	end

	// Monitor: check status beats, predict for command beats, watchdog
	always @(posedge clk) begin
		cmd_beat    = arst_n && cmd_if.valid && cmd_if.ready;
		status_beat = arst_n && status_if.valid && status_if.ready;
		if (status_beat) begin
			if (expected_status.size() == 0) begin
				errors++;
				$display("%0t: unexpected status beat, expected none, got %h",
					$time, status_if.data);
			end else begin
				status_t want;
				want = expected_status.pop_front();
				check_field("drive_level", 32'(want.drive_level),
					32'(status_if.data.drive_level));
				check_field("power_on", 32'(want.power_on), 32'(status_if.data.power_on));
				check_field("blink_active", 32'(want.blink_active),
					32'(status_if.data.blink_active));
				check_field("remaining_ms", want.remaining_ms, status_if.data.remaining_ms);
			end
		end
		if (cmd_beat) begin
			expected_status.push_back(next_status(cmd_if.data));
			events_done++;
		end
		if (arst_n) begin
			if (cmd_beat || status_beat)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		cmd_t c;
		int   added;
		int   n_ticks;

		arst_n          = 1'b0;
		cmd_if.valid    = 1'b0;
		cmd_if.data     = '0;
		status_if.ready = 1'b0;
		errors          = 0;
		quiet_cycles    = 0;
		src_gap         = 0;
		sink_wait       = 0;
		reset_mirror();

		// Directed events: extremes, every operation, each corner of the blink
		pending_cmds.push_back(cmd_t'{OP_TICK, 1'b0, 8'd0, 32'd0, 32'd0});
		pending_cmds.push_back(cmd_t'{OP_SPARE_LO, 1'b1, 8'hFF, '1, '1});
		pending_cmds.push_back(cmd_t'{OP_SPARE_HI, 1'b0, 8'h5A, 32'd3, 32'd3});
		pending_cmds.push_back(cmd_t'{OP_SET_LEVEL, 1'b0, 8'hFF, 32'd0, 32'd0});
		pending_cmds.push_back(cmd_t'{OP_SET_POWER, 1'b1, 8'd0, 32'd0, 32'd0});
		pending_cmds.push_back(cmd_t'{OP_SET_LEVEL, 1'b0, 8'd0, 32'd0, 32'd0});
		pending_cmds.push_back(cmd_t'{OP_SET_LEVEL, 1'b1, 8'd200, 32'd0, 32'd0});
		pending_cmds.push_back(cmd_t'{OP_TOGGLE, 1'b1, 8'd0, 32'd0, 32'd0});
		pending_cmds.push_back(cmd_t'{OP_TOGGLE, 1'b0, 8'd0, 32'd0, 32'd0});
		// shortest period: toggles on every tick, then runs out
		pending_cmds.push_back(cmd_t'{OP_BLINK, 1'b0, 8'd0, 32'd3, 32'd1});
		repeat (4) pending_cmds.push_back(cmd_t'{OP_TICK, 1'b0, 8'd0, 32'd0, 32'd0});
		// longest length and period
		pending_cmds.push_back(cmd_t'{OP_BLINK, 1'b0, 8'd0, '1, '1});
		pending_cmds.push_back(cmd_t'{OP_TICK, 1'b0, 8'd0, 32'd0, 32'd0});
		// restart while running
		pending_cmds.push_back(cmd_t'{OP_BLINK, 1'b0, 8'd0, 32'd5, 32'd2});
		repeat (2) pending_cmds.push_back(cmd_t'{OP_TICK, 1'b0, 8'd0, 32'd0, 32'd0});
		// power command cancels the blink
		pending_cmds.push_back(cmd_t'{OP_SET_POWER, 1'b0, 8'd0, 32'd0, 32'd0});
		pending_cmds.push_back(cmd_t'{OP_BLINK, 1'b0, 8'd0, 32'd0, 32'd5});
		pending_cmds.push_back(cmd_t'{OP_BLINK, 1'b0, 8'd0, 32'd6, 32'd3});
		pending_cmds.push_back(cmd_t'{OP_TICK, 1'b0, 8'd0, 32'd0, 32'd0});
		// zero period cancels a running blink
		pending_cmds.push_back(cmd_t'{OP_BLINK, 1'b0, 8'd0, 32'd4, 32'd0});

		// Random part: mostly blink runs with ticks, some loose commands
		added = 0;
		while (added < RANDOM_EVENTS) begin
			if ($urandom_range(0, 99) < 70) begin
				c = random_cmd(OP_BLINK);
				if ($urandom_range(0, 9) != 0)
					c.blink_length_ms = $urandom_range(1, 40);
				if ($urandom_range(0, 19) != 0)
					c.blink_period_ms = $urandom_range(1, 12);
				pending_cmds.push_back(c);
				added++;
				n_ticks = $urandom_range(0, 45);
				repeat (n_ticks) begin
					if ($urandom_range(0, 19) == 0)
						pending_cmds.push_back(random_cmd(3'($urandom_range(1, 7))));
					else
						pending_cmds.push_back(random_cmd(OP_TICK));
					added++;
				end
			end else begin
				pending_cmds.push_back(random_cmd(3'($urandom_range(0, 7))));
				added++;
			end
		end

		// Hold reset low, then release it on a falling edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_cmds.size() != 0 || cmd_if.valid)
			@(posedge clk);
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (expected_status.size() != 0) begin
			errors++;
			$display("%0t: %0d status beats never arrived", $time, expected_status.size());
		end
		$display("Ran %0d events: %0d blinks started, %0d ran out, %0d output toggles.",
			events_done, blinks_started, blinks_expired, blink_toggles);
		$display("Mismatches found: %0d", errors);
		if (errors == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
